[hdl/clt_pkg.sv]
// Package for the command-line tokenizer: phase and result codes, character
// constants, the request bundle types and the per-byte phase-machine functions.
// No dependencies.
package clt_pkg;

   localparam int BYTE_W            = 8;
   localparam int IDX_W             = 11;
   localparam int TOKEN_LIMIT_RESET = 1024;
   localparam int SLOTS             = 4;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      PH_WS,
      PH_WS_SLASH,
      PH_BLOCK,
      PH_BLOCK_STAR,
      PH_QUOTE,
      PH_BARE,
      PH_BARE_SLASH,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_END,
      KIND_DONE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  index;
   } result_type;

   // Outcome of one byte through the phase machine.
   typedef struct packed {
      phase_type                 phase;
      logic [IDX_W-1:0]          count;
      logic [1:0]                n;
      result_type [SLOTS-1:0]    res;
   } feed_type;

   // All results caused by one request, in order.
   typedef struct packed {
      logic [2:0]             n;
      result_type [SLOTS-1:0] res;
   } bundle_type;

   function automatic logic is_space(logic [BYTE_W-1:0] c);
      return (c != CH_NUL) && ((c <= CH_SPACE) || c[BYTE_W-1]);
   endfunction

   function automatic feed_type emit_res(feed_type f, kind_type k,
                                         logic [BYTE_W-1:0] b, logic [IDX_W-1:0] i);
      feed_type r;
      r = f;
      r.res[r.n] = '{kind: k, data: b, index: i};
      r.n = r.n + 2'd1;
      return r;
   endfunction

   function automatic feed_type finish_res(feed_type f);
      feed_type r;
      r = emit_res(f, KIND_DONE, CH_NUL, f.count);
      r.phase = PH_DONE;
      return r;
   endfunction

   function automatic feed_type end_token(feed_type f);
      return emit_res(f, KIND_END, CH_NUL, f.count - 1'b1);
   endfunction

   function automatic feed_type bare_byte(feed_type f, logic [BYTE_W-1:0] c,
                                          logic [IDX_W-1:0] lim);
      feed_type r;
      r = f;
      if (c == CH_NUL) begin
         r = finish_res(end_token(r));
      end else if (is_space(c)) begin
         r = end_token(r);
         if (r.count >= lim) r = finish_res(r);
         else r.phase = PH_WS;
      end else if (c == CH_QUOTE) begin
         r = end_token(r);
         if (r.count >= lim) begin
            r = finish_res(r);
         end else begin
            r.count = r.count + 1'b1;
            r.phase = PH_QUOTE;
         end
      end else if (c == CH_SLASH) begin
         r.phase = PH_BARE_SLASH;
      end else begin
         r = emit_res(r, KIND_CHAR, c, r.count - 1'b1);
         r.phase = PH_BARE;
      end
      return r;
   endfunction

   // One byte through the phase machine from the given phase and count.
   function automatic feed_type feed(phase_type ph, logic [IDX_W-1:0] cnt,
                                     logic [IDX_W-1:0] lim, logic [BYTE_W-1:0] c);
      feed_type r;
      r = '0;
      r.phase = ph;
      r.count = cnt;
      unique case (ph)
         PH_WS: begin
            if ((r.count >= lim) || (c == CH_NUL)) begin
               r = finish_res(r);
            end else if (is_space(c)) begin
               r.phase = PH_WS;
            end else if (c == CH_SLASH) begin
               r.phase = PH_WS_SLASH;
            end else if (c == CH_QUOTE) begin
               r.count = r.count + 1'b1;
               r.phase = PH_QUOTE;
            end else begin
               r.count = r.count + 1'b1;
               r = emit_res(r, KIND_CHAR, c, r.count - 1'b1);
               r.phase = PH_BARE;
            end
         end
         PH_WS_SLASH: begin
            if (c == CH_SLASH) begin
               r = finish_res(r);
            end else if (c == CH_STAR) begin
               r.phase = PH_BLOCK_STAR;
            end else begin
               r.count = r.count + 1'b1;
               r = emit_res(r, KIND_CHAR, CH_SLASH, r.count - 1'b1);
               r = bare_byte(r, c, lim);
            end
         end
         PH_BLOCK: begin
            if (c == CH_NUL) r = finish_res(r);
            else if (c == CH_STAR) r.phase = PH_BLOCK_STAR;
         end
         PH_BLOCK_STAR: begin
            if (c == CH_NUL) r = finish_res(r);
            else if (c == CH_SLASH) r.phase = PH_WS;
            else if (c != CH_STAR) r.phase = PH_BLOCK;
         end
         PH_QUOTE: begin
            if (c == CH_NUL) begin
               r = finish_res(end_token(r));
            end else if (c == CH_QUOTE) begin
               r = end_token(r);
               if (r.count >= lim) r = finish_res(r);
               else r.phase = PH_WS;
            end else begin
               r = emit_res(r, KIND_CHAR, c, r.count - 1'b1);
            end
         end
         PH_BARE: begin
            r = bare_byte(r, c, lim);
         end
         PH_BARE_SLASH: begin
            if (c == CH_SLASH) begin
               r = finish_res(end_token(r));
            end else if (c == CH_STAR) begin
               r = end_token(r);
               if (r.count >= lim) r = finish_res(r);
               else r.phase = PH_BLOCK_STAR;
            end else begin
               r = emit_res(r, KIND_CHAR, CH_SLASH, r.count - 1'b1);
               r = bare_byte(r, c, lim);
            end
         end
         PH_DONE: begin
            r.phase = PH_DONE;
         end
      endcase
      return r;
   endfunction

endpackage

[hdl/clt_front.sv]
// Front end of the tokenizer: accepts request bytes, runs the phase machine
// and hands each request's results as one bundle to the queue.
// Depends on clt_pkg.
module clt_front #(
   parameter int MAX_TOKENS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [clt_pkg::BYTE_W-1:0]           req_in_byte,
   input  logic                                 req_end_of_line,
   input  logic                                 csr_write_enable,
   input  logic [clt_pkg::IDX_W-1:0]            csr_write_data,
   input  logic                                 queue_full,
   output logic                                 push,
   output clt_pkg::bundle_type                  push_data
);
   import clt_pkg::*;

   localparam logic [IDX_W-1:0] LIMIT_AT_RESET = (TOKEN_LIMIT_RESET > MAX_TOKENS) ?
      IDX_W'(MAX_TOKENS) : IDX_W'(TOKEN_LIMIT_RESET);

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] limit_ff, limit_in;
   feed_type         first_feed, second_feed;
   logic             accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // The limit is clamped to the build maximum when it is written.
   assign limit_in = (int'(csr_write_data) > MAX_TOKENS) ? IDX_W'(MAX_TOKENS)
                                                         : csr_write_data;

   // The byte itself, then at end of line an implied zero byte.
   always_comb begin
      first_feed = feed(phase_ff, count_ff, limit_ff, req_in_byte);
      second_feed = '0;
      second_feed.phase = first_feed.phase;
      second_feed.count = first_feed.count;
      if (req_end_of_line) begin
         second_feed = feed(first_feed.phase, first_feed.count, limit_ff, CH_NUL);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_end_of_line) begin
            phase_in = PH_WS;
            count_in = '0;
         end else begin
            phase_in = first_feed.phase;
            count_in = first_feed.count;
         end
      end
   end

   always_comb begin
      push_data.n = {1'b0, first_feed.n} + {1'b0, second_feed.n};
      for (int i = 0; i < SLOTS; i++) begin
         if (3'(i) < {1'b0, first_feed.n}) begin
            push_data.res[i] = first_feed.res[2'(i)];
         end else begin
            push_data.res[i] = second_feed.res[2'(3'(i) - {1'b0, first_feed.n})];
         end
      end
      push = accept && (push_data.n != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         count_ff <= '0;
         limit_ff <= LIMIT_AT_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         if (csr_write_enable) limit_ff <= limit_in;
      end
   end

endmodule

[hdl/clt_queue.sv]
// Short queue of result bundles between the front and back ends.
// Depends on clt_pkg.
module clt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  clt_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output clt_pkg::bundle_type head
);
   import clt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full  = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[hdl/clt_back.sv]
// Back end of the tokenizer: walks the head bundle of the queue and presents
// its results one per cycle on the response channel while rsp_stall is low.
// Depends on clt_pkg.
module clt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        empty,
   input  clt_pkg::bundle_type         head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output clt_pkg::kind_type           rsp_kind,
   output logic [clt_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [clt_pkg::IDX_W-1:0]   rsp_token_index,
   output logic                        rsp_last
);
   import clt_pkg::*;

   logic [1:0] pos_ff, pos_in;
   result_type cur;
   logic       taken;

   assign cur             = head.res[pos_ff];
   assign rsp_valid       = !empty;
   assign rsp_kind        = cur.kind;
   assign rsp_out_byte    = cur.data;
   assign rsp_token_index = cur.index;
   assign rsp_last        = ({1'b0, pos_ff} == (head.n - 3'd1));

   assign taken = rsp_valid && !rsp_stall;
   assign pop   = taken && rsp_last;

   always_comb begin
      pos_in = pos_ff;
      if (taken) pos_in = rsp_last ? 2'd0 : pos_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else pos_ff <= pos_in;
   end

endmodule

[hdl/command_line_tokenizer.sv]
// Command-line tokenizer, top level.
// Request channel (req_valid / req_stall): one byte of a command line per
// request, with req_end_of_line on the final byte. A request is taken at a
// clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall): token characters, token ends and
// one line-finished marker per line; rsp_last flags the final response of a
// request. A request may cause zero to four responses.
// The first response of a request is shown once its bundle, registered in the
// queue, reaches the head. Throughput: one request per cycle while each gives at
// most one response and the receiver does not stall; a request with more
// responses holds the back end, as the single response port drains the queue.
// csr_write_enable / csr_write_data load the token limit (clamped to
// MAX_TOKENS); write only while the block is idle.
// Reset (synchronous) empties the two-entry queue, returns the parser to
// whitespace skipping with no tokens, and loads a limit of 1024 (or MAX_TOKENS if smaller).
// When the receiver stalls, the response holds; once the queue fills,
// req_stall rises until a bundle drains.
// Depends on clt_pkg, clt_front, clt_queue and clt_back.
module command_line_tokenizer #(
   parameter int MAX_TOKENS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [clt_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_end_of_line,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output clt_pkg::kind_type           rsp_kind,
   output logic [clt_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [clt_pkg::IDX_W-1:0]   rsp_token_index,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [clt_pkg::IDX_W-1:0]   csr_write_data
);
   import clt_pkg::*;

   logic       push, pop, full, empty;
   bundle_type push_data, head;

   clt_front #(.MAX_TOKENS(MAX_TOKENS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_line  (req_end_of_line),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (full),
      .push             (push),
      .push_data        (push_data)
   );

   clt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   clt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_last        (rsp_last)
   );

endmodule

[hdl/clt_checker.sv]
// Port-level checks for the command-line tokenizer, bound to the top level.
// Depends on clt_pkg and command_line_tokenizer.
module clt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input clt_pkg::kind_type           rsp_kind,
   input logic [clt_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic [clt_pkg::IDX_W-1:0]   rsp_token_index,
   input logic                        rsp_last
);
   import clt_pkg::*;

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_out_byte) && $stable(rsp_token_index) && $stable(rsp_last))
      else $error("stalled response changed");

   // Nothing follows the line-finished marker within the same request.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE) |-> rsp_last)
      else $error("line-finished response not last of its request");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_CHAR) |-> (rsp_out_byte == CH_NUL))
      else $error("nonzero byte on a marker response");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_token_index (rsp_token_index),
   .rsp_last        (rsp_last)
);
